// File: rtl/core/ring_deque_top_assert.svh
// Assertion macros shared by the ring deque checker.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef RING_DEQUE_TOP_ASSERT_SVH
`define RING_DEQUE_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define RDQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define RDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rdq_pkg.sv
// Package for the ring deque: field widths, operation and status codes, cell commands.
// No dependencies; every other file of the block but the assertion header refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 8;
    localparam int S_FIELD_W = OP_W + WORD_W;
    localparam int M_FIELD_W = WORD_W + STATUS_W + COUNT_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // The command that every cell of the chain carries out.
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH_FRONT = 3'd1,
        CELL_PUSH_BACK  = 3'd2,
        CELL_POP_FRONT  = 3'd3,
        CELL_POP_BACK   = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [WORD_W-1:0]  value;
    } cell_ctl_t;

    // Number of 4:1 stages needed to reduce depth leaves to one.
    function automatic int tree_levels(input int depth);
        int lv;
        int span;
        lv   = 1;
        span = 4;
        while (span < depth) begin
            lv   = lv + 1;
            span = span * 4;
        end
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rdq_cell.sv
// One storage cell of the deque chain: a word and a tail marker.
// Talks only to its two neighbors and the broadcast command; uses rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rdq_pkg::cell_ctl_t        ctl,
    input  wire logic [rdq_pkg::WORD_W-1:0] left_word,
    input  wire logic                      left_tail,
    input  wire logic [rdq_pkg::WORD_W-1:0] right_word,
    input  wire logic                      right_tail,
    output logic      [rdq_pkg::WORD_W-1:0] word,
    output logic                           tail,
    output logic      [rdq_pkg::WORD_W-1:0] tail_word
);

    logic [rdq_pkg::WORD_W-1:0] word_reg, word_next;
    logic                       tail_reg, tail_next;

    // The front moves by shifting the whole chain; the back moves by
    // passing the tail marker one cell along.
    always_comb begin
        word_next = word_reg;
        tail_next = tail_reg;
        case (ctl.cmd)
            rdq_pkg::CELL_PUSH_FRONT: begin
                word_next = left_word;
                tail_next = left_tail;
            end
            rdq_pkg::CELL_PUSH_BACK: begin
                if (left_tail) begin
                    word_next = ctl.value;
                end
                tail_next = left_tail;
            end
            rdq_pkg::CELL_POP_FRONT: begin
                word_next = right_word;
                tail_next = right_tail;
            end
            rdq_pkg::CELL_POP_BACK: begin
                tail_next = right_tail;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg <= 1'b0;
        end else begin
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign tail      = tail_reg;
    assign tail_word = tail_reg ? word_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/rdq_or_tree.sv
// Registered 4:1 OR reduction tree that picks the one marked word out of the chain.
// One register level per stage from leaves to root; uses rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_or_tree #(
    parameter int DEPTH  = 128,
    parameter int LEVELS = 4
) (
    input  wire logic                                 aclk,
    input  wire logic [DEPTH-1:0][rdq_pkg::WORD_W-1:0] leaf,
    output logic      [rdq_pkg::WORD_W-1:0]            root
);

    // Internal nodes laid out as a 4-ary heap; node n has children 4n+1 .. 4n+4.
    localparam int INT_N = ((4 ** LEVELS) - 1) / 3;

    logic [rdq_pkg::WORD_W-1:0] node_reg [INT_N];

    for (genvar n = 0; n < INT_N; n++) begin : g_node
        logic [3:0][rdq_pkg::WORD_W-1:0] kid;
        for (genvar c = 0; c < 4; c++) begin : g_kid
            localparam int CI = 4 * n + 1 + c;
            if (CI >= INT_N) begin : g_leaf
                if (CI - INT_N < DEPTH) begin : g_used
                    assign kid[c] = leaf[CI - INT_N];
                end else begin : g_pad
                    assign kid[c] = '0;
                end
            end else begin : g_inner
                assign kid[c] = node_reg[CI];
            end
        end
        always_ff @(posedge aclk) begin
            node_reg[n] <= kid[0] | kid[1] | kid[2] | kid[3];
        end
    end

    assign root = node_reg[0];

endmodule

`default_nettype wire

// File: rtl/core/ring_deque_top.sv
// Top level of the ring deque: stream ports, command decode, cell chain, result register.
// Instantiates rdq_cell and rdq_or_tree; uses rdq_pkg.
//
//  Channel  Direction  Payload (tdata, lowest bits first)            Pad
//  s_axis   in         op[2:0], value_in[34:3]                       [39:35] zero
//  m_axis   out        value_out[31:0], status[33:32], count[41:34]  [47:42] zero
//
// A request is accepted at a rising edge, and its result is loaded into the output register
// at that same edge. A push or pop that changes the contents holds off the following request
// until the OR tree, LEVELS stages deep (LEVELS = 4 at DEPTH 128), has delivered the new
// back word; peeks and refused requests do not hold off the next request.
// Reset clears only control state; no clearing pass is needed.
// A stalled result blocks new requests only while the output register is still full.
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_top #(
    parameter int DEPTH = 128
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // op, value_in
    input  wire logic [rdq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value_out, status, count
    output logic      [rdq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEVELS = rdq_pkg::tree_levels(DEPTH);
    localparam int SET_W  = $clog2(LEVELS + 1);
    localparam int PAD_W  = rdq_pkg::M_TDATA_W - rdq_pkg::M_FIELD_W;

    // Request fields.
    logic [rdq_pkg::OP_W-1:0]   s_op;
    logic [rdq_pkg::WORD_W-1:0] s_value;

    assign s_op    = s_axis_tdata[rdq_pkg::OP_W-1:0];
    assign s_value = s_axis_tdata[rdq_pkg::S_FIELD_W-1:rdq_pkg::OP_W];

    // Control state.
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SET_W-1:0] settle_reg, settle_next;
    logic             m_valid_reg, m_valid_next;

    // Result payload register.
    logic [rdq_pkg::WORD_W-1:0] m_value_reg;
    rdq_pkg::status_t           m_status_reg;
    logic [rdq_pkg::COUNT_W-1:0] m_count_reg;

    // Cell chain.
    logic [DEPTH-1:0][rdq_pkg::WORD_W-1:0] cell_word;
    logic [DEPTH-1:0][rdq_pkg::WORD_W-1:0] cell_tail_word;
    logic [DEPTH-1:0]                      cell_tail;
    logic [rdq_pkg::WORD_W-1:0]            back_word;
    rdq_pkg::cell_ctl_t                    cell_ctl;

    logic                       accept;
    logic                       empty;
    logic                       full;
    logic                       changes;
    rdq_pkg::cell_cmd_t         cmd;
    rdq_pkg::status_t           res_status;
    logic [rdq_pkg::WORD_W-1:0] res_value;
    logic [CNT_W-1:0]           res_fill;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_W'(DEPTH));

    // A new request waits for the back word to settle and for room in the result register.
    assign s_axis_tready = (settle_reg == '0) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the request into a chain command and its result.
    always_comb begin
        cmd        = rdq_pkg::CELL_HOLD;
        res_status = rdq_pkg::ST_OK;
        res_value  = '0;
        res_fill   = fill_reg;
        case (rdq_pkg::op_t'(s_op))
            rdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    res_status = rdq_pkg::ST_OVERFLOW;
                end else begin
                    cmd      = rdq_pkg::CELL_PUSH_FRONT;
                    res_fill = fill_reg + CNT_W'(1);
                end
            end
            rdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    res_status = rdq_pkg::ST_OVERFLOW;
                end else begin
                    cmd      = rdq_pkg::CELL_PUSH_BACK;
                    res_fill = fill_reg + CNT_W'(1);
                end
            end
            rdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    res_status = rdq_pkg::ST_UNDERFLOW;
                end else begin
                    cmd       = rdq_pkg::CELL_POP_FRONT;
                    res_value = cell_word[0];
                    res_fill  = fill_reg - CNT_W'(1);
                end
            end
            rdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    res_status = rdq_pkg::ST_UNDERFLOW;
                end else begin
                    cmd       = rdq_pkg::CELL_POP_BACK;
                    res_value = back_word;
                    res_fill  = fill_reg - CNT_W'(1);
                end
            end
            rdq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    res_status = rdq_pkg::ST_UNDERFLOW;
                end else begin
                    res_value = cell_word[0];
                end
            end
            rdq_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    res_status = rdq_pkg::ST_UNDERFLOW;
                end else begin
                    res_value = back_word;
                end
            end
            default: begin
            end
        endcase
    end

    assign changes        = accept && (cmd != rdq_pkg::CELL_HOLD);
    assign cell_ctl.cmd   = accept ? cmd : rdq_pkg::CELL_HOLD;
    assign cell_ctl.value = s_value;

    // Next values of the control registers.
    always_comb begin
        fill_next    = accept ? res_fill : fill_reg;
        settle_next  = settle_reg;
        m_valid_next = m_valid_reg;
        if (changes) begin
            settle_next = SET_W'(LEVELS);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SET_W'(1);
        end
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            settle_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            settle_reg  <= settle_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_value_reg  <= res_value;
            m_status_reg <= res_status;
            m_count_reg  <= rdq_pkg::COUNT_W'(res_fill);
        end
    end

    // Cell 0 holds the front word; the cell carrying the tail marker holds the back word.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [rdq_pkg::WORD_W-1:0] lw;
        logic [rdq_pkg::WORD_W-1:0] rw;
        logic                       lt;
        logic                       rt;

        if (i == 0) begin : g_first
            assign lw = s_value;
            assign lt = empty;
        end else begin : g_mid_l
            assign lw = cell_word[i-1];
            assign lt = cell_tail[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rw = '0;
            assign rt = 1'b0;
        end else begin : g_mid_r
            assign rw = cell_word[i+1];
            assign rt = cell_tail[i+1];
        end

        rdq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .left_word  (lw),
            .left_tail  (lt),
            .right_word (rw),
            .right_tail (rt),
            .word       (cell_word[i]),
            .tail       (cell_tail[i]),
            .tail_word  (cell_tail_word[i])
        );
    end

    // Only the tail cell drives a nonzero word, so an OR over the chain yields the back word.
    rdq_or_tree #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_back_tree (
        .aclk (aclk),
        .leaf (cell_tail_word),
        .root (back_word)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_count_reg, m_status_reg, m_value_reg};

endmodule

`default_nettype wire

// File: rtl/core/rdq_checker.sv
// Port-level checker for the ring deque, bound to ring_deque_top.
// Uses rdq_pkg field widths and the macros of ring_deque_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_deque_top_assert.svh"

module rdq_checker #(
    parameter int DEPTH = 128
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [rdq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready
);

    localparam int ST_LO = rdq_pkg::WORD_W;
    localparam int CN_LO = rdq_pkg::WORD_W + rdq_pkg::STATUS_W;

    logic [rdq_pkg::WORD_W-1:0]   out_value;
    logic [rdq_pkg::STATUS_W-1:0] out_status;
    logic [rdq_pkg::COUNT_W-1:0]  out_count;
    logic                         in_seen;

    assign out_value  = m_axis_tdata[rdq_pkg::WORD_W-1:0];
    assign out_status = m_axis_tdata[CN_LO-1:ST_LO];
    assign out_count  = m_axis_tdata[rdq_pkg::M_FIELD_W-1:CN_LO];
    assign in_seen    = s_axis_tvalid && s_axis_tready;

    `RDQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    `RDQ_ASSERT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `RDQ_ASSERT(a_err_zero, aclk, aresetn, m_axis_tvalid && out_status != rdq_pkg::ST_OK |-> out_value == '0, "refused request returned a word")

    `RDQ_ASSERT(a_ovf_full, aclk, aresetn, m_axis_tvalid && out_status == rdq_pkg::ST_OVERFLOW |-> out_count == rdq_pkg::COUNT_W'(DEPTH), "overflow while not full")

    `RDQ_ASSERT(a_result_follows, aclk, aresetn, in_seen |=> m_axis_tvalid, "accepted request gave no result")

endmodule

bind ring_deque_top rdq_checker #(
    .DEPTH (DEPTH)
) u_rdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// File: verif/ring_deque_top_tb.sv
// Self-checking testbench for ring_deque_top: random and directed deque requests over the stream ports.
// Depends on rdq_pkg for widths, operation and status codes; needs no files or arguments.
`timescale 1ns / 1ps

module ring_deque_top_tb;

    // Ring size of the block under test. It must match the instance parameter below.
    localparam int DEPTH = 128;

    // The block ignores op codes 6 and 7. They have no package name, so they are named here.
    localparam logic [rdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [rdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    // If no transaction happens on either channel for this many cycles, the run is stuck.
    // The slowest correct gap is a sender gap plus a long receiver stall plus the
    // OR-tree latency.
    localparam int STALL_LIMIT = 2000;

    // Extra cycles to wait after the last result. This covers the OR-tree latency with margin.
    localparam int DRAIN_CYCLES = 20;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic [rdq_pkg::WORD_W-1:0]   value;
        logic [rdq_pkg::STATUS_W-1:0] status;
        logic [rdq_pkg::COUNT_W-1:0]  count;
    } deque_result_t;

    // The scoreboard keeps its own copy of the deque contents. It turns each accepted
    // request into the result that the block should return, and it checks the results
    // in arrival order.
    class deque_scoreboard;
        logic [rdq_pkg::WORD_W-1:0] ring [DEPTH];
        int                         head;
        int                         fill;
        deque_result_t              awaited [$];
        int                         errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction

        // Applies one request to the shadow deque and queues the result it should produce.
        function void note_request(logic [rdq_pkg::OP_W-1:0] op,
                                   logic [rdq_pkg::WORD_W-1:0] word);
            deque_result_t r;
            int            back;
            r.value  = '0;
            r.status = rdq_pkg::ST_OK;
            back     = (head + fill - 1 + DEPTH) % DEPTH;
            case (op)
                rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.status = rdq_pkg::ST_OVERFLOW;
                    end else if (op == rdq_pkg::OP_PUSH_FRONT) begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = word;
                        fill++;
                    end else begin
                        ring[(head + fill) % DEPTH] = word;
                        fill++;
                    end
                end
                rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_PEEK_FRONT: begin
                    if (fill == 0) begin
                        r.status = rdq_pkg::ST_UNDERFLOW;
                    end else begin
                        r.value = ring[head];
                        if (op == rdq_pkg::OP_POP_FRONT) begin
                            head = (head + 1) % DEPTH;
                            fill--;
                        end
                    end
                end
                rdq_pkg::OP_POP_BACK, rdq_pkg::OP_PEEK_BACK: begin
                    if (fill == 0) begin
                        r.status = rdq_pkg::ST_UNDERFLOW;
                    end else begin
                        r.value = ring[back];
                        if (op == rdq_pkg::OP_POP_BACK) fill--;
                    end
                end
                default: begin
                    // The spare codes do nothing. They report the current fill level.
                end
            endcase
            r.count = rdq_pkg::COUNT_W'(fill);
            awaited.insert(awaited.size(), r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [rdq_pkg::M_TDATA_W-1:0] tdata);
            deque_result_t got;
            deque_result_t want;
            got.value  = tdata[rdq_pkg::WORD_W-1:0];
            got.status = tdata[rdq_pkg::WORD_W +: rdq_pkg::STATUS_W];
            got.count  = tdata[rdq_pkg::WORD_W+rdq_pkg::STATUS_W +: rdq_pkg::COUNT_W];
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result value=%h status=%0d count=%0d",
                                 got.value, got.status, got.count));
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (got.value !== want.value)
                report($sformatf("value_out got %h want %h", got.value, want.value));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.count !== want.count)
                report($sformatf("count got %0d want %0d", got.count, want.count));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [rdq_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;   // op, value_in
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [rdq_pkg::M_TDATA_W-1:0] m_axis_tdata;        // value_out, status, count
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;

    deque_scoreboard sb = new();

    // Sender burst state: how many requests remain before the next gap.
    int burst_left = 0;
    // Receiver stall pattern: the current mode, the cycles left in that mode, and
    // how long the current ready level still holds.
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;
    int idle_cycles = 0;

    ring_deque_top #(.DEPTH(DEPTH)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Monitor. Both channels are sampled at the rising edge, before the block's
    // registers update. Results are checked before the request of the same edge is
    // noted. A request's result can only appear on a later edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[rdq_pkg::OP_W-1:0],
                                s_axis_tdata[rdq_pkg::OP_W +: rdq_pkg::WORD_W]);
        end
    end

    // Watchdog. It counts consecutive cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ring_deque_top verification failed");
                $finish;
            end
        end
    end

    // Receiver. It switches at random intervals between three modes: always
    // ready, short random stalls, and long held ready levels.
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 400);
        end
        rx_mode_left--;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 2) != 0);
                default: begin
                    m_axis_tready <= ($urandom_range(0, 1) != 0);
                    rx_hold = $urandom_range(0, 19);
                end
            endcase
        end
    end

    // Presents one request at the falling edge and holds it until a rising edge
    // accepts it. Between bursts, valid drops for a random gap. A gap of zero
    // keeps requests back to back.
    task automatic send_request(logic [rdq_pkg::OP_W-1:0] op,
                                logic [rdq_pkg::WORD_W-1:0] word);
        int gap;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(rdq_pkg::S_TDATA_W - rdq_pkg::S_FIELD_W){1'b0}}, word, op};
        do @(posedge aclk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Random word. It is biased toward the sign and magnitude extremes now and then.
    function automatic logic [rdq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random request. push_pct sets how far the mix leans toward pushes. A high share
    // drives the deque into overflow, and a low share drains it into underflow.
    function automatic logic [rdq_pkg::OP_W-1:0] pick_op(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        if (roll < push_pct)
            return $urandom_range(0, 1) ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_BACK;
        case ($urandom_range(0, 5))
            0, 1: return rdq_pkg::OP_POP_FRONT;
            2, 3: return rdq_pkg::OP_POP_BACK;
            4: return rdq_pkg::OP_PEEK_FRONT;
            default: return rdq_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    initial begin
        int push_mix [6];
        push_mix = '{85, 15, 50, 92, 8, 55};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. It covers every op on an empty deque, the spare codes, a front
        // push while the head sits at ring index zero, extreme words at both ends, an
        // emptying pop, and reuse of the ring after the head has wrapped.
        send_request(rdq_pkg::OP_POP_FRONT,  32'h1111_1111);
        send_request(rdq_pkg::OP_POP_BACK,   32'h2222_2222);
        send_request(rdq_pkg::OP_PEEK_FRONT, 32'hFFFF_FFFF);
        send_request(rdq_pkg::OP_PEEK_BACK,  32'h0000_0000);
        send_request(OP_SPARE_6,             32'hDEAD_BEEF);
        send_request(OP_SPARE_7,             32'h0000_0000);
        send_request(rdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(rdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(rdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(rdq_pkg::OP_PUSH_BACK,  32'h0000_0000);
        send_request(rdq_pkg::OP_PEEK_FRONT, 32'h0000_0000);
        send_request(rdq_pkg::OP_PEEK_BACK,  32'hFFFF_FFFF);
        send_request(OP_SPARE_7,             32'h1234_5678);
        send_request(rdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rdq_pkg::OP_POP_FRONT,  32'h0000_0000);
        send_request(rdq_pkg::OP_POP_FRONT,  32'h0000_0000);
        send_request(rdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rdq_pkg::OP_PUSH_BACK,  32'hA5A5_A5A5);
        send_request(rdq_pkg::OP_PEEK_FRONT, 32'h0000_0000);
        send_request(rdq_pkg::OP_POP_FRONT,  32'h0000_0000);
        send_request(rdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
        send_request(rdq_pkg::OP_PEEK_BACK,  32'h0000_0000);
        send_request(rdq_pkg::OP_POP_FRONT,  32'h0000_0000);

        // Random part. Six phases of 200 requests each lean in turn toward filling,
        // draining and an even mix, so the deque passes through full and empty several
        // times at varying head positions.
        foreach (push_mix[p]) begin
            repeat (200) send_request(pick_op(push_mix[p]), pick_word());
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // Wait for every expected result, then allow time for any late extra one.
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("ring_deque_top verification clean");
        end else begin
            $display("ring_deque_top verification failed");
        end
        $finish;
    end

endmodule
